>>> rtl/dda_pkg.sv
// Package for the DDA line rasteriser: default sizes, opcodes and the
// command and status structs that pass between controller and datapath.
// Depends on nothing.
package dda_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    // Input opcodes.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // start item accepted: load endpoints, emit start point
        logic div_first; // first quotient step (integer bit, no shift)
        logic div_step;  // one quotient step of both dividers
        logic advance;   // advance item on an active line: step and emit
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_zero; // endpoints on the input are equal
        logic last_adv;  // the next advance reaches the end point
    } t_dp_sts;

endpackage

>>> rtl/dda_if.sv
// Channel interfaces of the DDA line rasteriser: the command input and the
// point output, each with valid/ready handshake. Depends on nothing.
interface dda_in_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, opcode, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dda_out_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

>>> rtl/dda_datapath.sv
// Datapath of the DDA line rasteriser: endpoint deltas, two shared-step
// restoring dividers, position accumulators and the output payload.
// Depends on dda_pkg.
module dda_datapath #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  dda_pkg::t_dp_cmd      i_cmd,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output dda_pkg::t_dp_sts      o_sts,
    output logic [COORD_BITS-1:0] o_point_x,
    output logic [COORD_BITS-1:0] o_point_y,
    output logic                  o_last_point
);
    import dda_pkg::*;

    localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
    localparam int INC_W = FRAC_BITS + 2;
    localparam int QUO_W = FRAC_BITS + 1;
    localparam int REM_W = COORD_BITS + 1;

    logic                  neg_x, neg_y;
    logic [COORD_BITS-1:0] adx, ady, step;
    logic [REM_W-1:0]      t_x, t_y, rem_nx, rem_ny;
    logic                  ge_x, ge_y;
    logic [INC_W-1:0]      inc_x, inc_y;
    logic [ACC_W-1:0]      acc_nx, acc_ny;

    logic [ACC_W-1:0]      r_acc_x, r_acc_y;
    logic [REM_W-1:0]      r_rem_x, r_rem_y;
    logic [QUO_W-1:0]      r_quo_x, r_quo_y;
    logic                  r_neg_x, r_neg_y;
    logic [COORD_BITS-1:0] r_step;
    logic [COORD_BITS-1:0] r_steps_left;
    logic [COORD_BITS-1:0] r_point_x, r_point_y;
    logic                  r_last;

    always_comb begin
        neg_x = i_x_end < i_x_start;
        neg_y = i_y_end < i_y_start;
        adx   = neg_x ? i_x_start - i_x_end : i_x_end - i_x_start;
        ady   = neg_y ? i_y_start - i_y_end : i_y_end - i_y_start;
        step  = (adx > ady) ? adx : ady;
    end

    // One restoring step per cycle; the first step takes the integer bit
    // without shifting, since the magnitude never exceeds the step count.
    always_comb begin
        t_x    = i_cmd.div_first ? r_rem_x : {r_rem_x[REM_W-2:0], 1'b0};
        t_y    = i_cmd.div_first ? r_rem_y : {r_rem_y[REM_W-2:0], 1'b0};
        ge_x   = t_x >= {1'b0, r_step};
        ge_y   = t_y >= {1'b0, r_step};
        rem_nx = ge_x ? t_x - {1'b0, r_step} : t_x;
        rem_ny = ge_y ? t_y - {1'b0, r_step} : t_y;
    end

    // Signed increments from the unsigned quotients.
    always_comb begin
        inc_x  = r_neg_x ? INC_W'(-{1'b0, r_quo_x}) : {1'b0, r_quo_x};
        inc_y  = r_neg_y ? INC_W'(-{1'b0, r_quo_y}) : {1'b0, r_quo_y};
        acc_nx = r_acc_x + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
        acc_ny = r_acc_y + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_x      <= {1'b0, i_x_start, {FRAC_BITS{1'b0}}};
            r_acc_y      <= {1'b0, i_y_start, {FRAC_BITS{1'b0}}};
            r_rem_x      <= {1'b0, adx};
            r_rem_y      <= {1'b0, ady};
            r_quo_x      <= '0;
            r_quo_y      <= '0;
            r_neg_x      <= neg_x;
            r_neg_y      <= neg_y;
            r_step       <= step;
            r_steps_left <= step;
            r_point_x    <= i_x_start;
            r_point_y    <= i_y_start;
            r_last       <= o_sts.step_zero;
        end else if (i_cmd.div_step) begin
            r_rem_x <= rem_nx;
            r_rem_y <= rem_ny;
            r_quo_x <= {r_quo_x[QUO_W-2:0], ge_x};
            r_quo_y <= {r_quo_y[QUO_W-2:0], ge_y};
        end else if (i_cmd.advance) begin
            r_acc_x      <= acc_nx;
            r_acc_y      <= acc_ny;
            r_steps_left <= r_steps_left - 1'b1;
            r_point_x    <= acc_nx[FRAC_BITS +: COORD_BITS];
            r_point_y    <= acc_ny[FRAC_BITS +: COORD_BITS];
            r_last       <= o_sts.last_adv;
        end
    end

    assign o_sts.step_zero = (i_x_start == i_x_end) && (i_y_start == i_y_end);
    assign o_sts.last_adv  = r_steps_left == COORD_BITS'(1);
    assign o_point_x       = r_point_x;
    assign o_point_y       = r_point_y;
    assign o_last_point    = r_last;

endmodule

>>> rtl/dda_ctrl.sv
// Controller of the DDA line rasteriser: accepts items, sequences the
// divider and owns the output valid and the line-active flag.
// Depends on dda_pkg.
module dda_ctrl #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_opcode,
    input  logic             i_out_ready,
    input  dda_pkg::t_dp_sts i_sts,
    output dda_pkg::t_dp_cmd o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    import dda_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             r_line_active;
    logic             in_acc;
    logic             emit;
    logic             cnt_end;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign cnt_end    = r_cnt == CNT_W'(FRAC_BITS);

    always_comb begin
        o_cmd.load      = in_acc && (i_in_opcode == OP_START);
        o_cmd.advance   = in_acc && (i_in_opcode == OP_ADVANCE) && r_line_active;
        o_cmd.div_step  = r_state == S_DIV;
        o_cmd.div_first = (r_state == S_DIV) && (r_cnt == '0);
        emit            = o_cmd.load || o_cmd.advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_line_active <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (o_cmd.load) begin
                        r_line_active <= !i_sts.step_zero;
                        if (!i_sts.step_zero) begin
                            r_state <= S_DIV;
                        end
                    end else if (o_cmd.advance && i_sts.last_adv) begin
                        r_line_active <= 1'b0;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (cnt_end) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

    // A start item with distinct endpoints always enters the divide phase.
    a_load_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load && !i_sts.step_zero |=> r_state == S_DIV)
        else $error("divide phase not entered after start");

    // No item is taken while the quotients are being formed.
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> !o_in_ready)
        else $error("input ready during divide");

    // The divide counter never runs past the last quotient bit.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt <= CNT_W'(FRAC_BITS))
        else $error("divide counter overrun");

    // A line ends only on its final advance or on a new start.
    a_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_line_active)
            |-> $past((o_cmd.advance && i_sts.last_adv) || o_cmd.load))
        else $error("line ended unexpectedly");

endmodule

>>> rtl/dda_line_rasterizer.sv
// Top level of the DDA line rasteriser: joins controller and datapath to
// the input and output channels. Depends on dda_pkg, dda_if, dda_ctrl and
// dda_datapath.
//
//  Channel  Direction  Payload                                   Handshake
//  i_in     in         opcode, x_start, y_start, x_end, y_end    valid/ready
//  o_out    out        point_x, point_y, last_point              valid/ready
//
// A start item's start point is offered in the cycle after the item is
// taken. The two increments are then formed by restoring division, one
// quotient bit per cycle for both axes at once, so the block takes no item
// while it divides after a start with distinct endpoints; a start with
// equal endpoints gives one point marked last and needs no division.
// Advance items are taken one per cycle, each yielding one point; the only
// limit is the output register, which accepts a new item in the cycle its
// held point is taken. Reset is synchronous and active low; it clears the
// controller state, the output valid and the line-active flag. An advance
// item with no line in progress is accepted and yields nothing.
module dda_line_rasterizer #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dda_in_if.sink    i_in,
    dda_out_if.source o_out
);
    import dda_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    dda_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    // Payload registers of the datapath feed the output channel directly.
    dda_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_x_start    (i_in.x_start),
        .i_y_start    (i_in.y_start),
        .i_x_end      (i_in.x_end),
        .i_y_end      (i_in.y_end),
        .o_sts        (sts),
        .o_point_x    (o_out.point_x),
        .o_point_y    (o_out.point_y),
        .o_last_point (o_out.last_point)
    );

endmodule
